@@ src/rpn_pkg.sv @@
`default_nettype none

package rpn_pkg;

  // Data path width of the Q format values.
  localparam int unsigned DATA_W = 32;

  // Fraction bits of the fixed-point format.
  localparam int unsigned FRAC_BITS = 16;

  // Default stack depth.
  localparam int unsigned STACK_DEPTH = 16;

  // Shift-add steps for a multiply, restoring steps for a divide.
  localparam int unsigned MUL_STEPS = 32;
  localparam int unsigned DIV_STEPS = 31;
  localparam int unsigned STEP_W    = 6;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_FEW  = 3'd1,
    ST_DIV0 = 3'd2,
    ST_MANY = 3'd3,
    ST_OVF  = 3'd4
  } status_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div0;
  } alu_rsp_t;

endpackage

`default_nettype wire

@@ src/rpn_alu.sv @@
`default_nettype none

// Iterative arithmetic unit: one 34-bit adder/subtractor serves add, subtract,
// the shift-add multiply, the restoring divide and the final negation.
module rpn_alu (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rpn_pkg::alu_req_t            req_i,
  input  wire logic signed [rpn_pkg::DATA_W-1:0] lhs_i,
  input  wire logic signed [rpn_pkg::DATA_W-1:0] rhs_i,
  output rpn_pkg::alu_rsp_t                 rsp_o,
  output logic signed [rpn_pkg::DATA_W-1:0] result_o
);

  typedef enum logic [2:0] {
    A_IDLE,
    A_ADD,
    A_MUL,
    A_DIV,
    A_FIN
  } alu_state_e;

  alu_state_e          state_q;
  rpn_pkg::op_e        op_q;
  logic [31:0]         hi_q;
  logic [31:0]         lo_q;
  logic [31:0]         mb_q;
  logic [31:0]         rem_q;
  logic [rpn_pkg::STEP_W-1:0] cnt_q;
  logic                neg_q;
  logic                ovf_q;
  logic                done_q;
  logic                div0_q;
  logic [31:0]         result_q;

  logic [31:0] lhs_u, rhs_u, l_mag, r_mag;
  logic [63:0] dvd, dvs_top;
  logic        div_big;
  logic [33:0] opa, opb, sum;
  logic        sub;
  logic [63:0] mag64;
  logic        big;
  logic        add_ovf;

  assign lhs_u = lhs_i;
  assign rhs_u = rhs_i;
  assign l_mag = lhs_u[31] ? (32'd0 - lhs_u) : lhs_u;
  assign r_mag = rhs_u[31] ? (32'd0 - rhs_u) : rhs_u;

  // Scaled dividend; a quotient of 2^31 or more saturates at once.
  assign dvd     = {32'd0, l_mag} << rpn_pkg::FRAC_BITS;
  assign dvs_top = {1'b0, r_mag, 31'd0};
  assign div_big = (dvd >= dvs_top);

  // Magnitude before sign and saturation.
  always_comb begin
    if (op_q == rpn_pkg::OP_MUL) begin
      mag64 = {hi_q, lo_q} >> rpn_pkg::FRAC_BITS;
    end else begin
      mag64 = {33'd0, lo_q[30:0]};
    end
    big = ovf_q || (|mag64[63:31]);
  end

  // Shared adder operand selection.
  always_comb begin
    unique case (state_q)
      A_ADD: begin
        opa = {{2{hi_q[31]}}, hi_q};
        opb = {{2{lo_q[31]}}, lo_q};
        sub = (op_q == rpn_pkg::OP_SUB);
      end
      A_MUL: begin
        opa = {2'b00, hi_q};
        opb = lo_q[0] ? {2'b00, mb_q} : 34'd0;
        sub = 1'b0;
      end
      A_DIV: begin
        opa = {1'b0, rem_q, lo_q[30]};
        opb = {2'b00, mb_q};
        sub = 1'b1;
      end
      A_FIN: begin
        opa = 34'd0;
        opb = {2'b00, mag64[31:0]};
        sub = 1'b1;
      end
      default: begin
        opa = 34'd0;
        opb = 34'd0;
        sub = 1'b0;
      end
    endcase
    sum     = opa + (sub ? ~opb : opb) + {33'd0, sub};
    add_ovf = (sum[32] != sum[31]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= A_IDLE;
      op_q     <= rpn_pkg::OP_ADD;
      hi_q     <= '0;
      lo_q     <= '0;
      mb_q     <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      neg_q    <= 1'b0;
      ovf_q    <= 1'b0;
      done_q   <= 1'b0;
      div0_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= 1'b0;
      div0_q <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            op_q  <= req_i.op;
            neg_q <= lhs_u[31] ^ rhs_u[31];
            ovf_q <= 1'b0;
            unique case (req_i.op)
              rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
                hi_q    <= lhs_u;
                lo_q    <= rhs_u;
                state_q <= A_ADD;
              end
              rpn_pkg::OP_MUL: begin
                hi_q    <= '0;
                lo_q    <= r_mag;
                mb_q    <= l_mag;
                cnt_q   <= rpn_pkg::STEP_W'(rpn_pkg::MUL_STEPS - 1);
                state_q <= A_MUL;
              end
              rpn_pkg::OP_DIV: begin
                if (r_mag == 32'd0) begin
                  done_q <= 1'b1;
                  div0_q <= 1'b1;
                end else begin
                  mb_q    <= r_mag;
                  rem_q   <= dvd[62:31];
                  lo_q    <= {1'b0, dvd[30:0]};
                  ovf_q   <= div_big;
                  cnt_q   <= rpn_pkg::STEP_W'(rpn_pkg::DIV_STEPS - 1);
                  state_q <= div_big ? A_FIN : A_DIV;
                end
              end
              default: state_q <= A_IDLE;
            endcase
          end
        end
        A_ADD: begin
          if (add_ovf) begin
            result_q <= sum[33] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
          end else begin
            result_q <= sum[31:0];
          end
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        A_MUL: begin
          hi_q <= sum[32:1];
          lo_q <= {sum[0], lo_q[31:1]};
          if (cnt_q == '0) begin
            state_q <= A_FIN;
          end else begin
            cnt_q <= cnt_q - rpn_pkg::STEP_W'(1);
          end
        end
        A_DIV: begin
          rem_q <= sum[33] ? opa[31:0] : sum[31:0];
          lo_q  <= {lo_q[30:0], ~sum[33]};
          if (cnt_q == '0) begin
            state_q <= A_FIN;
          end else begin
            cnt_q <= cnt_q - rpn_pkg::STEP_W'(1);
          end
        end
        A_FIN: begin
          if (big) begin
            result_q <= neg_q ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
          end else begin
            result_q <= neg_q ? sum[31:0] : mag64[31:0];
          end
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.div0 = div0_q;
  assign result_o   = result_q;

endmodule

`default_nettype wire

@@ src/rpn_stack_evaluator.sv @@
`default_nettype none

// Channel   Direction  Handshake                Payload
// -------   ---------  -----------------------  ----------------------------------------
// token     in         in_valid_i / in_stall_o  is_operator_i, opcode_i,
//                                               operand_value_i, last_token_i
// result    out        out_valid_o/out_stall_i  result_value_o, status_o
//
// A new token is taken only once the last one is done: an operand is pushed, an
// operator reads its operands and runs the ALU (multiply 32 shift-add steps, divide
// 31 restoring steps, none for a saturating quotient or a zero divisor). Tokens
// after an error pass through untouched; a last token then loads the result.
// Reset clears the count, the error code and the result register, not the stack.
// A stalled result blocks only a later last token, which waits until it is free.

module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                is_operator_i,
  input  wire logic [1:0]                          opcode_i,
  input  wire logic signed [rpn_pkg::DATA_W-1:0]   operand_value_i,
  input  wire logic                                last_token_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [rpn_pkg::DATA_W-1:0]        result_value_o,
  output logic [2:0]                               status_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_R,
    S_READ_L,
    S_ALU,
    S_END,
    S_EMIT
  } seq_state_e;

  seq_state_e        state_q;
  logic [CW-1:0]     count_q;
  rpn_pkg::status_e  err_q;

  // Latched token.
  logic              tok_op_q;
  rpn_pkg::op_e      tok_opc_q;
  logic [31:0]       tok_val_q;
  logic              tok_last_q;

  // Right operand, held while the left one is read.
  logic [31:0]       rhs_q;

  // Result register.
  logic              out_valid_q;
  logic [31:0]       out_value_q;
  rpn_pkg::status_e  out_status_q;

  // Stack memory.
  logic [31:0]       stack_mem [STACK_DEPTH];
  logic [31:0]       rd_q;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [31:0]       wr_data;

  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic              full, few;
  logic              emit_load;
  rpn_pkg::status_e  emit_status;

  rpn_pkg::alu_req_t alu_req;
  rpn_pkg::alu_rsp_t alu_rsp;
  logic signed [31:0] alu_result;

  assign cnt_m1 = count_q - CW'(1);
  assign cnt_m2 = count_q - CW'(2);
  assign full   = (count_q >= CW'(STACK_DEPTH));
  assign few    = (count_q < CW'(2));

  // Read the right operand, then the left; otherwise keep the bottom entry
  // on the port for the final result.
  always_comb begin
    unique case (state_q)
      S_DECODE: rd_addr = cnt_m1[AW-1:0];
      S_READ_R: rd_addr = cnt_m2[AW-1:0];
      default:  rd_addr = '0;
    endcase
  end

  // Push an operand, or the operator's result; both land at the count.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = tok_val_q;
    if (state_q == S_DECODE && err_q == rpn_pkg::ST_OK && !tok_op_q && !full) begin
      wr_en = 1'b1;
    end else if (state_q == S_ALU && alu_rsp.done && !alu_rsp.div0) begin
      wr_en   = 1'b1;
      wr_data = alu_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[count_q[AW-1:0]] <= wr_data;
    end
    rd_q <= stack_mem[rd_addr];
  end

  assign alu_req.start = (state_q == S_READ_L);
  assign alu_req.op    = tok_opc_q;

  rpn_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .lhs_i    (rd_q),
    .rhs_i    (rhs_q),
    .rsp_o    (alu_rsp),
    .result_o (alu_result)
  );

  // Final status: first error wins, else judge the number of values left.
  always_comb begin
    if (err_q != rpn_pkg::ST_OK) begin
      emit_status = err_q;
    end else if (count_q == CW'(1)) begin
      emit_status = rpn_pkg::ST_OK;
    end else if (count_q == '0) begin
      emit_status = rpn_pkg::ST_FEW;
    end else begin
      emit_status = rpn_pkg::ST_MANY;
    end
  end

  assign emit_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      err_q        <= rpn_pkg::ST_OK;
      tok_op_q     <= 1'b0;
      tok_opc_q    <= rpn_pkg::OP_ADD;
      tok_val_q    <= '0;
      tok_last_q   <= 1'b0;
      rhs_q        <= '0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= rpn_pkg::ST_OK;
    end else begin
      // Drop the result once it has been transferred.
      if (emit_load) begin
        out_valid_q  <= 1'b1;
        out_status_q <= emit_status;
        out_value_q  <= (emit_status == rpn_pkg::ST_OK) ? rd_q : 32'd0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            tok_op_q   <= is_operator_i;
            tok_opc_q  <= rpn_pkg::op_e'(opcode_i);
            tok_val_q  <= operand_value_i;
            tok_last_q <= last_token_i;
            state_q    <= S_DECODE;
          end
        end
        S_DECODE: begin
          // Once an error is set, pass tokens through untouched.
          if (err_q != rpn_pkg::ST_OK) begin
            state_q <= S_END;
          end else if (!tok_op_q) begin
            if (full) begin
              err_q <= rpn_pkg::ST_OVF;
            end else begin
              count_q <= count_q + CW'(1);
            end
            state_q <= S_END;
          end else if (few) begin
            err_q   <= rpn_pkg::ST_FEW;
            state_q <= S_END;
          end else begin
            state_q <= S_READ_R;
          end
        end
        S_READ_R: begin
          rhs_q   <= rd_q;
          state_q <= S_READ_L;
        end
        S_READ_L: begin
          // Both operands are consumed, even by a divide by zero.
          count_q <= cnt_m2;
          state_q <= S_ALU;
        end
        S_ALU: begin
          if (alu_rsp.done) begin
            if (alu_rsp.div0) begin
              err_q <= rpn_pkg::ST_DIV0;
            end else begin
              count_q <= count_q + CW'(1);
            end
            state_q <= S_END;
          end
        end
        S_END: begin
          state_q <= tok_last_q ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          // Hold until the result register is free, then start afresh.
          if (emit_load) begin
            count_q <= '0;
            err_q   <= rpn_pkg::ST_OK;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;

endmodule

`default_nettype wire

@@ src/rpn_checker.sv @@
`default_nettype none

module rpn_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_i,
  input wire logic               out_valid_i,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] result_value_i,
  input wire logic [2:0]         status_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(result_value_i) && $stable(status_i))
    else $error("result payload changed while stalled");

  // Every token transfer makes the block busy in the next cycle.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("token taken without going busy");

  // A failed expression reports zero.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != rpn_pkg::ST_OK |-> result_value_i == 32'sd0)
    else $error("non-zero value with error status");

  // A new result only follows a cycle of work on a token.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_stall_i))
    else $error("result appeared without a token in progress");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_i     (in_stall_o),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_value_i (result_value_o),
  .status_i       (status_o)
);

`default_nettype wire

@@ tb/tb_rpn_stack_evaluator.sv @@
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator;

  localparam int unsigned TOKEN_TARGET = 1150;
  localparam int unsigned QUIET_FROM   = 1000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam longint     SUM_MAX      = 64'sd2147483647;
  localparam longint     SUM_MIN      = -64'sd2147483648;
  localparam logic [31:0] ONE_Q       = 32'h0001_0000;

  typedef struct packed {
    bit           is_op;
    rpn_pkg::op_e op;
    logic [31:0]  value;
    bit           last;
  } token_t;

  typedef struct packed {
    logic [31:0]      value;
    rpn_pkg::status_e status;
  } outcome_t;

  // One line of the directed script: a token, how often to repeat it, and an
  // optional result typed in by hand for the last token of an expression.
  typedef struct packed {
    bit               is_op;
    rpn_pkg::op_e     op;
    logic [31:0]      value;
    bit               last;
    int unsigned      reps;
    bit               pinned;
    logic [31:0]      exp_value;
    rpn_pkg::status_e exp_status;
  } script_row_t;

  localparam int unsigned SCRIPT_LEN = 30;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic                              is_operator_i;
  logic [1:0]                        opcode_i;
  logic signed [rpn_pkg::DATA_W-1:0] operand_value_i;
  logic                              last_token_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [rpn_pkg::DATA_W-1:0] result_value_o;
  logic [2:0]                        status_o;

  // Predictor state: a private copy of the evaluation stack.
  logic signed [31:0] eval_stack [rpn_pkg::STACK_DEPTH];
  int unsigned        eval_depth;
  rpn_pkg::status_e   eval_error;

  outcome_t           pending_results [$];
  int unsigned        tokens_sent;
  int unsigned        mismatch_count;
  int unsigned        gap_odds;
  bit                 quiet_tail;
  script_row_t        script [SCRIPT_LEN];

  rpn_stack_evaluator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .is_operator_i   (is_operator_i),
    .opcode_i        (opcode_i),
    .operand_value_i (operand_value_i),
    .last_token_i    (last_token_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_value_o  (result_value_o),
    .status_o        (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run (every token a multiply,
  // every gap and every output stall at their longest).
  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Queue an expected outcome behind the ones already waiting.
  task automatic book_result(input outcome_t res);
    pending_results = {pending_results, res};
  endtask

  function automatic logic [31:0] clamp_sum(input longint v);
    if (v > SUM_MAX) return rpn_pkg::Q_MAX;
    if (v < SUM_MIN) return rpn_pkg::Q_MIN;
    return v[31:0];
  endfunction

  // Put the sign back on an unsigned magnitude and saturate.
  function automatic logic [31:0] signed_magnitude(input bit neg, input logic [63:0] mag);
    logic [63:0] flipped;
    flipped = -mag;
    if (neg) begin
      if (mag >= 64'h8000_0000) return rpn_pkg::Q_MIN;
      return flipped[31:0];
    end
    if (mag > 64'h7FFF_FFFF) return rpn_pkg::Q_MAX;
    return mag[31:0];
  endfunction

  // Advance the predictor by one token; return 1 with the outcome when the
  // token closes an expression.
  function automatic bit evaluate_token(input token_t tok, output outcome_t res);
    longint      lhs;
    longint      rhs;
    logic [63:0] lmag;
    logic [63:0] rmag;
    logic [31:0] word;
    bit          neg;
    res = '0;
    word = '0;
    if (eval_error == rpn_pkg::ST_OK) begin
      if (tok.is_op) begin
        if (eval_depth < 2) begin
          eval_error = rpn_pkg::ST_FEW;
        end else begin
          rhs = longint'(eval_stack[eval_depth-1]);
          lhs = longint'(eval_stack[eval_depth-2]);
          eval_depth -= 2;
          neg  = (lhs < 0) != (rhs < 0);
          lmag = (lhs < 0) ? -lhs : lhs;
          rmag = (rhs < 0) ? -rhs : rhs;
          case (tok.op)
            rpn_pkg::OP_ADD: word = clamp_sum(lhs + rhs);
            rpn_pkg::OP_SUB: word = clamp_sum(lhs - rhs);
            rpn_pkg::OP_MUL:
              word = signed_magnitude(neg, (lmag * rmag) >> rpn_pkg::FRAC_BITS);
            rpn_pkg::OP_DIV: begin
              if (rmag == 0) eval_error = rpn_pkg::ST_DIV0;
              else word = signed_magnitude(neg, (lmag << rpn_pkg::FRAC_BITS) / rmag);
            end
          endcase
          // A divide by zero consumes both operands and pushes nothing.
          if (eval_error == rpn_pkg::ST_OK) begin
            eval_stack[eval_depth] = word;
            eval_depth++;
          end
        end
      end else if (eval_depth >= rpn_pkg::STACK_DEPTH) begin
        eval_error = rpn_pkg::ST_OVF;
      end else begin
        eval_stack[eval_depth] = tok.value;
        eval_depth++;
      end
    end
    if (!tok.last) return 1'b0;
    if (eval_error != rpn_pkg::ST_OK) begin
      res.status = eval_error;
    end else if (eval_depth == 1) begin
      res.status = rpn_pkg::ST_OK;
      res.value  = eval_stack[0];
    end else if (eval_depth == 0) begin
      res.status = rpn_pkg::ST_FEW;
    end else begin
      res.status = rpn_pkg::ST_MANY;
    end
    eval_depth = 0;
    eval_error = rpn_pkg::ST_OK;
    return 1'b1;
  endfunction

  // Offer one token, hold it until the transfer, then book its result.
  task automatic send_token(input token_t tok, input bit pinned, input outcome_t pinned_res);
    outcome_t model_res;
    if (gap_odds != 0 && !quiet_tail && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    is_operator_i   <= tok.is_op;
    opcode_i        <= tok.op;
    operand_value_i <= tok.value;
    last_token_i    <= tok.last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tokens_sent++;
    if (evaluate_token(tok, model_res))
      book_result(pinned ? pinned_res : model_res);
  endtask

  // Mix of zero, the extremes, small Q16.16 numbers and raw random words.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return rpn_pkg::Q_MAX;
      2:       return rpn_pkg::Q_MIN;
      3, 4:    return $urandom;
      5:       return $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic token_t random_token();
    token_t tok;
    tok.is_op = $urandom_range(0, 1);
    tok.op    = rpn_pkg::op_e'($urandom_range(0, 3));
    tok.value = pick_value();
    tok.last  = 1'b0;
    return tok;
  endfunction

  // Mostly well-formed expressions; the rest are broken token runs and
  // runs that push past the top of the stack.
  task automatic send_expression();
    int unsigned shape;
    int unsigned left;
    int unsigned depth;
    int unsigned span;
    token_t      tok;
    shape = $urandom_range(0, 99);
    if (shape < 75) begin
      left  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, rpn_pkg::STACK_DEPTH)
                                          : $urandom_range(1, 6);
      depth = 0;
      while (left > 0 || depth > 1) begin
        tok = random_token();
        tok.is_op = !(depth < 2 || (left > 0 && $urandom_range(0, 1) == 1));
        if (tok.is_op) begin
          depth--;
        end else begin
          left--;
          depth++;
        end
        tok.last = (left == 0 && depth == 1);
        send_token(tok, 1'b0, '0);
      end
    end else begin
      span = (shape < 92) ? $urandom_range(1, 12)
                          : $urandom_range(rpn_pkg::STACK_DEPTH, rpn_pkg::STACK_DEPTH + 4);
      for (int i = 0; i < span; i++) begin
        tok = random_token();
        // Fill the stack first so that later operands hit the top.
        if (shape >= 92 && i < rpn_pkg::STACK_DEPTH) tok.is_op = 1'b0;
        tok.last = (i == span - 1);
        send_token(tok, 1'b0, '0);
      end
    end
  endtask

  // Result side: alternate stall bursts with calm stretches; drop the
  // stalls altogether for the tail of the run.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!quiet_tail) begin
        if ($urandom_range(0, 2) == 0) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end else begin
          repeat ($urandom_range(0, 30)) @(posedge clk_i);
        end
      end
    end
  end

  // Compare every result transfer with the oldest booked outcome.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result %h status %0d with nothing expected",
                                result_value_o, status_o));
      end else begin
        want = pending_results.pop_front();
        if (result_value_o !== want.value)
          flag_mismatch($sformatf("result_value %h, expected %h",
                                  result_value_o, want.value));
        if (status_o !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
      end
    end
  end

  initial begin
    token_t   tok;
    outcome_t pinned_res;

    // Directed script. Rows with a typed result cover the empty expression,
    // saturation at both ends, the error codes and a single value; the rest
    // go through the predictor.
    script = '{
      '{1'b1, rpn_pkg::OP_ADD, 32'h0000_0000, 1'b1, 1,  1'b1, 32'h0000_0000, rpn_pkg::ST_FEW},
      '{1'b0, rpn_pkg::OP_ADD, 32'h7FFF_FFFF, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b0, rpn_pkg::OP_SUB, 32'h0000_0001, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b1, rpn_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b1, 1,  1'b1, 32'h7FFF_FFFF, rpn_pkg::ST_OK},
      '{1'b0, rpn_pkg::OP_MUL, 32'h8000_0000, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b0, rpn_pkg::OP_DIV, 32'h0000_0001, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b1, rpn_pkg::OP_SUB, 32'h0000_0000, 1'b1, 1,  1'b1, 32'h8000_0000, rpn_pkg::ST_OK},
      '{1'b0, rpn_pkg::OP_ADD, 32'h7FFF_FFFF, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b0, rpn_pkg::OP_ADD, 32'h7FFF_FFFF, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b1, rpn_pkg::OP_MUL, 32'h0000_0000, 1'b1, 1,  1'b1, 32'h7FFF_FFFF, rpn_pkg::ST_OK},
      '{1'b0, rpn_pkg::OP_ADD, 32'h8000_0000, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b0, rpn_pkg::OP_ADD, ONE_Q,         1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b1, rpn_pkg::OP_MUL, 32'h0000_0000, 1'b1, 1,  1'b1, 32'h8000_0000, rpn_pkg::ST_OK},
      '{1'b0, rpn_pkg::OP_ADD, 32'h8000_0000, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b0, rpn_pkg::OP_ADD, 32'hFFFF_0000, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b1, rpn_pkg::OP_DIV, 32'h0000_0000, 1'b1, 1,  1'b1, 32'h7FFF_FFFF, rpn_pkg::ST_OK},
      // divide by zero, then an operator that the sticky error must ignore
      '{1'b0, rpn_pkg::OP_ADD, 32'h0005_0000, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b0, rpn_pkg::OP_ADD, 32'h0000_0000, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b1, rpn_pkg::OP_DIV, 32'h0000_0000, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b1, rpn_pkg::OP_ADD, 32'h0000_0000, 1'b1, 1,  1'b1, 32'h0000_0000, rpn_pkg::ST_DIV0},
      '{1'b0, rpn_pkg::OP_ADD, 32'h0001_8000, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b0, rpn_pkg::OP_ADD, 32'hFFFD_C000, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b1, rpn_pkg::OP_MUL, 32'h0000_0000, 1'b1, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b0, rpn_pkg::OP_DIV, 32'h0000_0003, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b0, rpn_pkg::OP_MUL, 32'h0000_0004, 1'b1, 1,  1'b1, 32'h0000_0000, rpn_pkg::ST_MANY},
      '{1'b0, rpn_pkg::OP_SUB, 32'hFFFF_FFFF, 1'b1, 1,  1'b1, 32'hFFFF_FFFF, rpn_pkg::ST_OK},
      // fill the stack, then push once more
      '{1'b0, rpn_pkg::OP_ADD, ONE_Q,         1'b0, 17, 1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b1, rpn_pkg::OP_SUB, 32'h0000_0000, 1'b1, 1,  1'b1, 32'h0000_0000, rpn_pkg::ST_OVF},
      // operator short of operands as the last token of an expression
      '{1'b0, rpn_pkg::OP_ADD, 32'h0002_0000, 1'b0, 1,  1'b0, 32'h0000_0000, rpn_pkg::ST_OK},
      '{1'b1, rpn_pkg::OP_MUL, 32'h0000_0000, 1'b1, 1,  1'b1, 32'h0000_0000, rpn_pkg::ST_FEW}
    };

    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    is_operator_i   <= 1'b0;
    opcode_i        <= rpn_pkg::OP_ADD;
    operand_value_i <= '0;
    last_token_i    <= 1'b0;
    eval_depth      = 0;
    eval_error      = rpn_pkg::ST_OK;
    tokens_sent     = 0;
    mismatch_count  = 0;
    gap_odds        = 4;
    quiet_tail      = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[r]) begin
      tok        = '{script[r].is_op, script[r].op, script[r].value, script[r].last};
      pinned_res = '{script[r].exp_value, script[r].exp_status};
      repeat (script[r].reps) send_token(tok, script[r].pinned, pinned_res);
    end

    // Random expressions; vary the input gap rate from one to the next and
    // run the tail without any idling.
    while (tokens_sent < TOKEN_TARGET) begin
      quiet_tail = (tokens_sent >= QUIET_FROM);
      gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
      send_expression();
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
